>>> rtl/core/touch_grid_tap_qualifier_assert.svh
// Assertion macros shared by the checker of the touch grid tap qualifier.
// Every macro expects signals named clk and rst_n in the scope that uses it.
`ifndef TOUCH_GRID_TAP_QUALIFIER_ASSERT_SVH
`define TOUCH_GRID_TAP_QUALIFIER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TGTQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TGTQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/tgtq_pkg.sv
// Package for the touch grid tap qualifier: types, codes and fixed constants.
// Used by every module in rtl/core; depends on nothing else.
`default_nettype none

package tgtq_pkg;

    localparam int GRID_COLS     = 3;
    localparam int GRID_ROWS     = 3;
    localparam int CURSOR_MARGIN = 8;

    localparam logic [8:0] CORNER_W = 9'd36;
    localparam logic [8:0] CORNER_H = 9'd18;
    localparam logic [3:0] NO_CELL  = 4'd15;

    // View modes.
    localparam logic [1:0] VIEW_LAUNCHER = 2'd0;
    localparam logic [1:0] VIEW_3D       = 2'd1;
    localparam logic [1:0] VIEW_NOTES    = 2'd2;

    // Per-cell action codes; anything else launches the cell's program.
    localparam logic [1:0] ACT_NOTES = 2'd1;
    localparam logic [1:0] ACT_3D    = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MIN_PRESS = 2'd0;
    localparam logic [1:0] CFG_WINDOW    = 2'd1;
    localparam logic [1:0] CFG_ACTIONS   = 2'd2;

    localparam logic [7:0]  MIN_PRESS_RESET = 8'd2;
    localparam logic [15:0] WINDOW_RESET    = 16'd60;
    localparam logic [17:0] ACTIONS_RESET   = 18'h20100;

    typedef struct packed {
        logic [8:0]  touch_x;
        logic [8:0]  touch_y;
        logic        pressed;
        logic [31:0] now_tick;
    } sample_t;

    typedef struct packed {
        logic [7:0]  min_press_ticks;
        logic [15:0] double_tap_window;
        logic [17:0] cell_actions;
    } cfg_t;

    // Grid lookup for one position: hit flag, cell index and clamped cursor.
    typedef struct packed {
        logic       hit;
        logic [3:0] grid_idx;
        logic [8:0] cursor_x;
        logic [8:0] cursor_y;
    } cell_hit_t;

    typedef struct packed {
        logic [1:0]  view_mode;
        logic [3:0]  selected_cell;
        logic [8:0]  cursor_x;
        logic [8:0]  cursor_y;
        logic        tap_event;
        logic        open_event;
        logic        launch_request;
        logic [31:0] tap_total;
        logic [31:0] open_total;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/core/tgtq_cell_locate.sv
// Maps a touch position to a 3x3 grid cell and a clamped cursor position.
// Pure combinational logic; depends on tgtq_pkg.
`default_nettype none

module tgtq_cell_locate #(
    parameter int PANEL_WIDTH   = 240,
    parameter int REGION_HEIGHT = 168,
    parameter int STATUS_HEIGHT = 14
) (
    input  logic [8:0]           touch_x,
    input  logic [8:0]           touch_y,
    output tgtq_pkg::cell_hit_t  loc
);
    import tgtq_pkg::*;

    localparam int GRID_H = (REGION_HEIGHT > STATUS_HEIGHT) ?
                            (REGION_HEIGHT - STATUS_HEIGHT) : 0;
    localparam int CELL_W = PANEL_WIDTH / GRID_COLS;
    localparam int CELL_H = GRID_H / GRID_ROWS;
    localparam int LIM_X  = (PANEL_WIDTH > CURSOR_MARGIN) ? (PANEL_WIDTH - CURSOR_MARGIN) : 0;
    localparam int LIM_Y  = (GRID_H > CURSOR_MARGIN) ? (GRID_H - CURSOR_MARGIN) : 0;

    localparam logic [9:0] PW_L  = 10'(PANEL_WIDTH);
    localparam logic [9:0] GH_L  = 10'(GRID_H);
    localparam logic [9:0] CW1_L = 10'(CELL_W);
    localparam logic [9:0] CW2_L = 10'(2 * CELL_W);
    localparam logic [9:0] CW3_L = 10'(3 * CELL_W);
    localparam logic [9:0] CH1_L = 10'(CELL_H);
    localparam logic [9:0] CH2_L = 10'(2 * CELL_H);
    localparam logic [9:0] CH3_L = 10'(3 * CELL_H);
    localparam logic [9:0] LX_L  = 10'(LIM_X);
    localparam logic [9:0] LY_L  = 10'(LIM_Y);

    logic [9:0] xe;
    logic [9:0] ye;
    logic [1:0] col;
    logic [1:0] row;
    logic       col_ok;
    logic       row_ok;

    assign xe = {1'b0, touch_x};
    assign ye = {1'b0, touch_y};

    // Constant-divisor column and row search done as three compares each.
    always_comb
    begin
        col    = 2'd0;
        col_ok = 1'b1;
        if (xe < CW1_L)
        begin
            col = 2'd0;
        end
        else if (xe < CW2_L)
        begin
            col = 2'd1;
        end
        else if (xe < CW3_L)
        begin
            col = 2'd2;
        end
        else
        begin
            col_ok = 1'b0;
        end

        row    = 2'd0;
        row_ok = 1'b1;
        if (ye < CH1_L)
        begin
            row = 2'd0;
        end
        else if (ye < CH2_L)
        begin
            row = 2'd1;
        end
        else if (ye < CH3_L)
        begin
            row = 2'd2;
        end
        else
        begin
            row_ok = 1'b0;
        end
    end

    always_comb
    begin
        loc.hit = col_ok && row_ok && (xe < PW_L) && (ye < GH_L) &&
                  (CELL_W != 0) && (CELL_H != 0);
        loc.grid_idx = {1'b0, row, 1'b0} + {2'b00, row} + {2'b00, col};
        loc.cursor_x = (xe < LX_L) ? touch_x : LX_L[8:0];
        loc.cursor_y = (ye < LY_L) ? touch_y : LY_L[8:0];
    end

endmodule

`default_nettype wire

>>> rtl/core/tgtq_tap_state.sv
// Tap and double-tap state: view mode, selection, press timer and counters.
// Computes the result of one sample and updates state on advance; uses tgtq_pkg.
`default_nettype none

module tgtq_tap_state #(
    parameter int PANEL_WIDTH   = 240,
    parameter int REGION_HEIGHT = 168,
    parameter int STATUS_HEIGHT = 14
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  tgtq_pkg::sample_t    sample,
    input  tgtq_pkg::cell_hit_t  loc,
    input  tgtq_pkg::cfg_t       cfg,
    output tgtq_pkg::result_t    result
);
    import tgtq_pkg::*;

    localparam int GRID_H = (REGION_HEIGHT > STATUS_HEIGHT) ?
                            (REGION_HEIGHT - STATUS_HEIGHT) : 0;
    localparam logic [8:0] CUR_X_RESET = 9'((PANEL_WIDTH / GRID_COLS) / 2);
    localparam logic [8:0] CUR_Y_RESET = 9'((GRID_H / GRID_ROWS) / 2);

    logic [1:0]  mode_reg, mode_next;
    logic [3:0]  sel_reg, sel_next;
    logic [8:0]  cur_x_reg, cur_x_next;
    logic [8:0]  cur_y_reg, cur_y_next;
    logic        down_reg, down_next;
    logic [31:0] press_start_reg, press_start_next;
    logic [31:0] prev_time_reg, prev_time_next;
    logic [3:0]  prev_cell_reg, prev_cell_next;
    logic [31:0] taps_reg, taps_next;
    logic [31:0] opens_reg, opens_next;

    logic [31:0] held_ticks;
    logic [31:0] gap_ticks;
    logic [31:0] act_shift;
    logic [1:0]  act;
    logic        tap;
    logic        open;
    logic        launch;

    assign held_ticks = sample.now_tick - press_start_reg;
    assign gap_ticks  = sample.now_tick - prev_time_reg;
    assign act_shift  = {14'd0, cfg.cell_actions} >> {sel_reg, 1'b0};
    assign act        = act_shift[1:0];

    always_comb
    begin
        mode_next        = mode_reg;
        sel_next         = sel_reg;
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        down_next        = down_reg;
        press_start_next = press_start_reg;
        prev_time_next   = prev_time_reg;
        prev_cell_next   = prev_cell_reg;
        taps_next        = taps_reg;
        opens_next       = opens_reg;
        tap              = 1'b0;
        open             = 1'b0;
        launch           = 1'b0;

        if (mode_reg != VIEW_LAUNCHER)
        begin
            // Only a press in the top-left corner does anything here.
            if (sample.pressed && (sample.touch_x < CORNER_W) && (sample.touch_y < CORNER_H))
            begin
                mode_next = VIEW_LAUNCHER;
            end
        end
        else if (sample.pressed)
        begin
            if (!down_reg)
            begin
                press_start_next = sample.now_tick;
                if (loc.hit)
                begin
                    sel_next   = loc.grid_idx;
                    cur_x_next = loc.cursor_x;
                    cur_y_next = loc.cursor_y;
                end
            end
            down_next = 1'b1;
        end
        else if (down_reg)
        begin
            down_next = 1'b0;
            if (held_ticks >= {24'd0, cfg.min_press_ticks})
            begin
                tap       = 1'b1;
                taps_next = taps_reg + 32'd1;
                if ((prev_cell_reg == sel_reg) && (gap_ticks < {16'd0, cfg.double_tap_window}))
                begin
                    open       = 1'b1;
                    opens_next = opens_reg + 32'd1;
                    case (act)
                        ACT_NOTES: mode_next = VIEW_NOTES;
                        ACT_3D:    mode_next = VIEW_3D;
                        default:   launch    = 1'b1;
                    endcase
                    prev_cell_next = NO_CELL;
                    prev_time_next = 32'd0;
                end
                else
                begin
                    prev_cell_next = sel_reg;
                    prev_time_next = sample.now_tick;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= VIEW_LAUNCHER;
            sel_reg         <= 4'd0;
            cur_x_reg       <= CUR_X_RESET;
            cur_y_reg       <= CUR_Y_RESET;
            down_reg        <= 1'b0;
            press_start_reg <= 32'd0;
            prev_time_reg   <= 32'd0;
            prev_cell_reg   <= NO_CELL;
            taps_reg        <= 32'd0;
            opens_reg       <= 32'd0;
        end
        else if (advance)
        begin
            mode_reg        <= mode_next;
            sel_reg         <= sel_next;
            cur_x_reg       <= cur_x_next;
            cur_y_reg       <= cur_y_next;
            down_reg        <= down_next;
            press_start_reg <= press_start_next;
            prev_time_reg   <= prev_time_next;
            prev_cell_reg   <= prev_cell_next;
            taps_reg        <= taps_next;
            opens_reg       <= opens_next;
        end
    end

    always_comb
    begin
        result.view_mode      = mode_next;
        result.selected_cell  = sel_next;
        result.cursor_x       = cur_x_next;
        result.cursor_y       = cur_y_next;
        result.tap_event      = tap;
        result.open_event     = open;
        result.launch_request = launch;
        result.tap_total      = taps_next;
        result.open_total     = opens_next;
    end

endmodule

`default_nettype wire

>>> rtl/core/touch_grid_tap_qualifier.sv
// Top level of the touch grid tap qualifier: stream ports, configuration
// registers, input and result registers. Uses tgtq_pkg, tgtq_cell_locate, tgtq_tap_state.
`default_nettype none

// Touch grid tap qualifier. Each accepted touch sample produces exactly one
// result transaction carrying the view mode, selection, cursor, tap/open/launch
// events and running tap and open counts after that sample. The block takes
// one sample per clock cycle in steady state while the master side does not
// stall: a sample sits in the input register; as it leaves, the tap state is
// updated and the result is loaded into the output register, which offers it
// on the master side. The state update (press timer compare, double-tap window
// compare, mode and counter update) sets that rate. Backpressure on the master
// side holds the result register and, once the input register is also full,
// drops s_axis_tready; a new sample is still taken while a finished result
// waits if the input register is empty or that result leaves in the same
// cycle. Configuration writes are always accepted (cfg_ready is tied high)
// and should only be issued while no sample is in flight. Grid geometry
// follows from PANEL_WIDTH, REGION_HEIGHT and STATUS_HEIGHT.
module touch_grid_tap_qualifier #(
    parameter int PANEL_WIDTH   = 240,
    parameter int REGION_HEIGHT = 168,
    parameter int STATUS_HEIGHT = 14
) (
    input  logic        clk,
    input  logic        rst_n,

    // Sample input.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // touch_x[8:0], touch_y[17:9], now_tick[49:18], zero pad
    input  logic        s_axis_tuser,   // pressed

    // Result output.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // view_mode[1:0], selected_cell[5:2], cursor_x[14:6],
                                        // cursor_y[23:15], tap_event[24], open_event[25],
                                        // launch_request[26], tap_total[58:27],
                                        // open_total[90:59], zero pad

    // Configuration writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [17:0] cfg_data
);
    import tgtq_pkg::*;

    sample_t   in_data_reg;
    logic      in_valid_reg;
    result_t   out_data_reg;
    logic      out_valid_reg;
    cfg_t      cfg_reg;
    cell_hit_t loc;
    result_t   result;
    logic      advance;
    logic      in_take;

    // A sample is processed when the result register is free or draining.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_data_reg.touch_x  <= s_axis_tdata[8:0];
            in_data_reg.touch_y  <= s_axis_tdata[17:9];
            in_data_reg.now_tick <= s_axis_tdata[49:18];
            in_data_reg.pressed  <= s_axis_tuser;
        end
    end

    // Configuration registers; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_press_ticks   <= MIN_PRESS_RESET;
            cfg_reg.double_tap_window <= WINDOW_RESET;
            cfg_reg.cell_actions      <= ACTIONS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MIN_PRESS: cfg_reg.min_press_ticks   <= cfg_data[7:0];
                CFG_WINDOW:    cfg_reg.double_tap_window <= cfg_data[15:0];
                CFG_ACTIONS:   cfg_reg.cell_actions      <= cfg_data;
                default:       cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    tgtq_cell_locate #(
        .PANEL_WIDTH   (PANEL_WIDTH),
        .REGION_HEIGHT (REGION_HEIGHT),
        .STATUS_HEIGHT (STATUS_HEIGHT)
    ) u_locate (
        .touch_x (in_data_reg.touch_x),
        .touch_y (in_data_reg.touch_y),
        .loc     (loc)
    );

    tgtq_tap_state #(
        .PANEL_WIDTH   (PANEL_WIDTH),
        .REGION_HEIGHT (REGION_HEIGHT),
        .STATUS_HEIGHT (STATUS_HEIGHT)
    ) u_state (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .sample  (in_data_reg),
        .loc     (loc),
        .cfg     (cfg_reg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0,
                            out_data_reg.open_total,
                            out_data_reg.tap_total,
                            out_data_reg.launch_request,
                            out_data_reg.open_event,
                            out_data_reg.tap_event,
                            out_data_reg.cursor_y,
                            out_data_reg.cursor_x,
                            out_data_reg.selected_cell,
                            out_data_reg.view_mode};

endmodule

`default_nettype wire

>>> rtl/core/tgtq_checker.sv
// Port-level checker for the touch grid tap qualifier, bound to the top level.
// Depends on tgtq_pkg and on touch_grid_tap_qualifier_assert.svh for the assertion macros.
`default_nettype none
`include "touch_grid_tap_qualifier_assert.svh"

module tgtq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata
);
    import tgtq_pkg::*;

    logic       vld;
    logic       stalled;
    logic [1:0] view;
    logic [3:0] sel;
    logic       tap_evt;
    logic       open_evt;
    logic       launch_evt;
    logic       view_open;

    assign vld        = m_axis_tvalid;
    assign stalled    = m_axis_tvalid && !m_axis_tready;
    assign view       = m_axis_tdata[1:0];
    assign sel        = m_axis_tdata[5:2];
    assign tap_evt    = m_axis_tdata[24];
    assign open_evt   = m_axis_tdata[25];
    assign launch_evt = m_axis_tdata[26];
    assign view_open  = vld && open_evt && !launch_evt;

    // A stalled result stays offered and unchanged.
    `TGTQ_ASSERT_NEXT(a_result_hold, stalled, vld && $stable(m_axis_tdata), "result changed")

    // An open is always a tap, and a launch request is always an open.
    `TGTQ_ASSERT_SAME(a_open_is_tap, vld && open_evt, tap_evt, "open without tap")
    `TGTQ_ASSERT_SAME(a_launch_is_open, vld && launch_evt, open_evt, "launch without open")

    // An open that does not launch must leave the launcher view.
    `TGTQ_ASSERT_SAME(a_open_view, view_open, view != VIEW_LAUNCHER, "open kept launcher")

    // The selection never leaves the nine grid cells.
    `TGTQ_ASSERT_SAME(a_cell_range, vld, sel <= 4'd8, "selected cell out of range")

endmodule

bind touch_grid_tap_qualifier tgtq_checker u_checker (.*);

`default_nettype wire

>>> tb/touch_grid_tap_qualifier_tb.sv
// Self-checking testbench for touch_grid_tap_qualifier: a directed touch script, then random
// gestures under several register settings, each result checked against a tap-state predictor.
// Depends on tgtq_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module touch_grid_tap_qualifier_tb;

    import tgtq_pkg::*;

    // Geometry of the instance; the grid follows from these three values.
    localparam int PANEL_W  = 240;
    localparam int REGION_H = 168;
    localparam int BAR_H    = 14;

    localparam int GRID_H  = (REGION_H > BAR_H) ? REGION_H - BAR_H : 0;
    localparam int CELL_W  = PANEL_W / GRID_COLS;
    localparam int CELL_H  = GRID_H / GRID_ROWS;
    localparam int CLAMP_X = (PANEL_W > CURSOR_MARGIN) ? PANEL_W - CURSOR_MARGIN : 0;
    localparam int CLAMP_Y = (GRID_H > CURSOR_MARGIN) ? GRID_H - CURSOR_MARGIN : 0;

    localparam int HOLD_OFF_CYCLES = 64;
    localparam int PHASE_ITEMS     = 100;
    localparam int SETTLE_CYCLES   = 4;

    typedef struct {
        sample_t smp;
        bit      typed;
        result_t want;
    } touch_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;    // touch_x[8:0], touch_y[17:9], now_tick[49:18], zero pad
    logic        s_axis_tuser = 1'b0;  // pressed
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;         // view_mode[1:0], selected_cell[5:2], cursor_x[14:6],
                                       // cursor_y[23:15], tap_event[24], open_event[25],
                                       // launch_request[26], tap_total[58:27],
                                       // open_total[90:59], zero pad
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [17:0] cfg_data = '0;

    // Register copies kept by the predictor.
    logic [7:0]  cfg_min_press = MIN_PRESS_RESET;
    logic [15:0] cfg_window    = WINDOW_RESET;
    logic [17:0] cfg_actions   = ACTIONS_RESET;

    // Tap state kept by the predictor.
    logic [1:0]  mdl_mode;
    logic [3:0]  mdl_cell;
    logic [8:0]  mdl_cur_x;
    logic [8:0]  mdl_cur_y;
    logic        mdl_held;
    logic [31:0] mdl_press_tick;
    logic [31:0] mdl_tap_tick;
    logic [3:0]  mdl_tap_cell;
    logic [31:0] mdl_taps;
    logic [31:0] mdl_opens;

    result_t     tap_reports_q[$];
    touch_row_t  directed_rows[$];

    int          mismatches = 0;
    int          counted_items = 0;
    bit          steady = 1'b0;
    bit          hold_off_req = 1'b0;
    int          hold_off_left = 0;
    logic [31:0] touch_tick = '0;
    int          aim_cell = 0;

    touch_grid_tap_qualifier #(
        .PANEL_WIDTH  (PANEL_W),
        .REGION_HEIGHT(REGION_H),
        .STATUS_HEIGHT(BAR_H)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // Works out the result of one touch sample and advances the tap state.
    function automatic result_t qualify_touch(sample_t s);
        result_t     r;
        logic [3:0]  hit;
        logic [1:0]  action;
        logic [31:0] held_for;
        logic [31:0] since_tap;
        int          col;
        int          row;
        r = '0;
        if (mdl_mode != VIEW_LAUNCHER) begin
            // Any view other than the launcher only listens to the corner.
            if (s.pressed && s.touch_x < CORNER_W && s.touch_y < CORNER_H)
                mdl_mode = VIEW_LAUNCHER;
        end
        else if (s.pressed) begin
            if (!mdl_held) begin
                hit = NO_CELL;
                if (s.touch_y < GRID_H && s.touch_x < PANEL_W && CELL_W != 0 && CELL_H != 0)
                begin
                    col = s.touch_x / CELL_W;
                    row = s.touch_y / CELL_H;
                    if (col < GRID_COLS && row < GRID_ROWS)
                        hit = 4'(row * GRID_COLS + col);
                end
                // The timer starts even when the press misses every cell.
                mdl_press_tick = s.now_tick;
                if (hit != NO_CELL) begin
                    mdl_cur_x = (s.touch_x < CLAMP_X) ? s.touch_x : 9'(CLAMP_X);
                    mdl_cur_y = (s.touch_y < CLAMP_Y) ? s.touch_y : 9'(CLAMP_Y);
                    mdl_cell  = hit;
                end
            end
            mdl_held = 1'b1;
        end
        else if (mdl_held) begin
            mdl_held = 1'b0;
            held_for = s.now_tick - mdl_press_tick;
            if (held_for >= {24'd0, cfg_min_press}) begin
                r.tap_event = 1'b1;
                mdl_taps    = mdl_taps + 32'd1;
                since_tap   = s.now_tick - mdl_tap_tick;
                if (mdl_tap_cell == mdl_cell && since_tap < {16'd0, cfg_window}) begin
                    action       = 2'(cfg_actions >> (mdl_cell * 2));
                    r.open_event = 1'b1;
                    mdl_opens    = mdl_opens + 32'd1;
                    if (action == ACT_NOTES)
                        mdl_mode = VIEW_NOTES;
                    else if (action == ACT_3D)
                        mdl_mode = VIEW_3D;
                    else
                        r.launch_request = 1'b1;
                    mdl_tap_cell = NO_CELL;
                    mdl_tap_tick = '0;
                end
                else begin
                    mdl_tap_cell = mdl_cell;
                    mdl_tap_tick = s.now_tick;
                end
            end
        end
        r.view_mode     = mdl_mode;
        r.selected_cell = mdl_cell;
        r.cursor_x      = mdl_cur_x;
        r.cursor_y      = mdl_cur_y;
        r.tap_total     = mdl_taps;
        r.open_total    = mdl_opens;
        return r;
    endfunction

    // Tick steps are scaled to the current press limit and window so that
    // both sides of each compare are hit; a few steps jump anywhere.
    function automatic logic [31:0] next_tick();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            touch_tick = touch_tick + $urandom_range(0, 2 * int'(cfg_min_press) + 3);
        else if (pick < 85)
            touch_tick = touch_tick + $urandom_range(0, int'(cfg_window) * 5 / 4 + 4);
        else if (pick < 95)
            touch_tick = touch_tick + $urandom_range(0, 16);
        else
            touch_tick = touch_tick + $urandom;
        return touch_tick;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
        end
    endtask

    // One sample transaction; the expectation is queued at the edge that accepts it.
    // Each cycle before the offer idles with the same odds, so about a third of
    // the input cycles stay idle outside the steady phase.
    task automatic offer_sample(input sample_t s, input bit typed, input result_t want);
        result_t guess;
        bit      live;
        while (!steady && $urandom_range(0, 99) < 32) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tdata  <= {6'd0, s.now_tick, s.touch_y, s.touch_x};
        s_axis_tuser  <= s.pressed;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        live = (mdl_mode == VIEW_LAUNCHER) ||
               (s.pressed && s.touch_x < CORNER_W && s.touch_y < CORNER_H);
        guess = qualify_touch(s);
        tap_reports_q.push_back(typed ? want : guess);
        if (live)
            counted_items++;
    endtask

    // Stops offering samples and waits until every queued result has come out.
    task automatic wait_until_drained();
        s_axis_tvalid <= 1'b0;
        while (tap_reports_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Keeps cfg_valid high across back-to-back writes; the caller lowers it.
    task automatic write_register(input logic [1:0] idx, input logic [17:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_MIN_PRESS: cfg_min_press = value[7:0];
            CFG_WINDOW:    cfg_window    = value[15:0];
            CFG_ACTIONS:   cfg_actions   = value;
            default:       ;
        endcase
    endtask

    task automatic add_row(input logic [8:0] x, input logic [8:0] y, input logic p,
                           input logic [31:0] t);
        touch_row_t row;
        row.smp   = {x, y, p, t};
        row.typed = 1'b0;
        row.want  = '0;
        directed_rows.push_back(row);
    endtask

    task automatic add_checked_row(input logic [8:0] x, input logic [8:0] y, input logic p,
                                   input logic [31:0] t, input result_t want);
        touch_row_t row;
        row.smp   = {x, y, p, t};
        row.typed = 1'b1;
        row.want  = want;
        directed_rows.push_back(row);
    endtask

    task automatic aim_at_cell(input int idx, output logic [8:0] x, output logic [8:0] y);
        x = 9'((idx % GRID_COLS) * CELL_W + $urandom_range(0, CELL_W - 1));
        y = 9'((idx / GRID_COLS) * CELL_H + $urandom_range(0, CELL_H - 1));
    endtask

    // One random gesture. Most are complete taps on a grid cell, often the
    // same cell again so that double taps happen; the rest are presses off
    // the grid, single noise samples and corner presses that leave a view.
    task automatic play_gesture();
        sample_t s;
        int      kind;
        int      presses;
        kind = $urandom_range(0, 99);
        if (mdl_mode != VIEW_LAUNCHER && kind < 50) begin
            // Leave a view through the top-left corner.
            s.touch_x  = 9'($urandom_range(0, CORNER_W - 1));
            s.touch_y  = 9'($urandom_range(0, CORNER_H - 1));
            s.pressed  = 1'b1;
            s.now_tick = next_tick();
            offer_sample(s, 1'b0, '0);
        end
        else if (kind < 80) begin
            if ($urandom_range(0, 99) < 40)
                aim_cell = $urandom_range(0, GRID_COLS * GRID_ROWS - 1);
            aim_at_cell(aim_cell, s.touch_x, s.touch_y);
            s.pressed = 1'b1;
            presses   = $urandom_range(1, 3);
            for (int i = 0; i < presses; i++) begin
                s.now_tick = next_tick();
                offer_sample(s, 1'b0, '0);
                // Samples after the first one of a press may wander anywhere.
                if ($urandom_range(0, 1))
                    aim_at_cell($urandom_range(0, 8), s.touch_x, s.touch_y);
                else
                    s = {9'($urandom), 9'($urandom), 1'b1, s.now_tick};
            end
            s.pressed  = 1'b0;
            s.now_tick = next_tick();
            offer_sample(s, 1'b0, '0);
        end
        else if (kind < 90) begin
            // A press that misses the grid still times a tap.
            if ($urandom_range(0, 1)) begin
                s.touch_x = 9'($urandom_range(PANEL_W, 511));
                s.touch_y = 9'($urandom_range(0, 511));
            end
            else begin
                s.touch_x = 9'($urandom_range(0, 511));
                s.touch_y = 9'($urandom_range(GRID_ROWS * CELL_H, 511));
            end
            s.pressed  = 1'b1;
            s.now_tick = next_tick();
            offer_sample(s, 1'b0, '0);
            s.pressed  = 1'b0;
            s.now_tick = next_tick();
            offer_sample(s, 1'b0, '0);
        end
        else begin
            s = {9'($urandom), 9'($urandom), 1'($urandom), next_tick()};
            offer_sample(s, 1'b0, '0);
        end
    endtask

    // Result side: random stalls, a long hold-off on request, none while steady.
    always @(posedge clk) begin
        if (hold_off_req) begin
            hold_off_req  = 1'b0;
            hold_off_left = HOLD_OFF_CYCLES;
        end
        if (hold_off_left != 0) begin
            hold_off_left = hold_off_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= steady || ($urandom_range(0, 99) >= 32);
    end

    // Every result transaction is compared field by field with the oldest prediction.
    always @(posedge clk) begin : watch_results
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (tap_reports_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with nothing expected, data %h",
                             $realtime, m_axis_tdata);
            end
            else begin
                want = tap_reports_q.pop_front();
                check_field("view_mode", 32'(want.view_mode), 32'(m_axis_tdata[1:0]));
                check_field("selected_cell", 32'(want.selected_cell), 32'(m_axis_tdata[5:2]));
                check_field("cursor_x", 32'(want.cursor_x), 32'(m_axis_tdata[14:6]));
                check_field("cursor_y", 32'(want.cursor_y), 32'(m_axis_tdata[23:15]));
                check_field("tap_event", 32'(want.tap_event), 32'(m_axis_tdata[24]));
                check_field("open_event", 32'(want.open_event), 32'(m_axis_tdata[25]));
                check_field("launch_request", 32'(want.launch_request),
                            32'(m_axis_tdata[26]));
                check_field("tap_total", want.tap_total, m_axis_tdata[58:27]);
                check_field("open_total", want.open_total, m_axis_tdata[90:59]);
            end
        end
    end

    initial begin
        #3_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        logic [7:0]  set_min;
        logic [15:0] set_window;
        logic [17:0] set_actions;
        bit          held_off;
        bit          paused;

        mdl_mode       = VIEW_LAUNCHER;
        mdl_cell       = 4'd0;
        mdl_cur_x      = 9'(CELL_W / 2);
        mdl_cur_y      = 9'(CELL_H / 2);
        mdl_held       = 1'b0;
        mdl_press_tick = '0;
        mdl_tap_tick   = '0;
        mdl_tap_cell   = NO_CELL;
        mdl_taps       = '0;
        mdl_opens      = '0;

        // Directed script under the reset register values. Rows with a typed
        // result are obvious by inspection; the rest go through the predictor.
        add_checked_row(9'd0, 9'd0, 1'b0, 32'd0,        // release with no press held
                        {VIEW_LAUNCHER, 4'd0, 9'(CELL_W / 2), 9'(CELL_H / 2), 3'b000,
                         32'd0, 32'd0});
        add_checked_row(9'd0, 9'd0, 1'b1, 32'd100,      // corner of cell 0, no clamp
                        {VIEW_LAUNCHER, 4'd0, 9'd0, 9'd0, 3'b000, 32'd0, 32'd0});
        add_row(9'd511, 9'd511, 1'b1, 32'd101);         // later sample of the press
        add_checked_row(9'd0, 9'd0, 1'b0, 32'd101,      // too short to be a tap
                        {VIEW_LAUNCHER, 4'd0, 9'd0, 9'd0, 3'b000, 32'd0, 32'd0});
        add_row(9'd239, 9'd153, 1'b1, 32'd200);         // below the last full row
        add_row(9'd239, 9'd153, 1'b0, 32'd202);         // exact minimum: a tap
        add_row(9'd511, 9'd511, 1'b1, 32'd210);         // off the panel
        add_row(9'd511, 9'd511, 1'b0, 32'd212);         // double tap, cell 0 launches
        add_row(9'd239, 9'd152, 1'b1, 32'd300);         // cell 8 with both clamps
        add_row(9'd239, 9'd152, 1'b0, 32'd305);
        add_row(9'd200, 9'd120, 1'b1, 32'd310);
        add_row(9'd200, 9'd120, 1'b0, 32'd315);         // opens the 3D view
        add_row(9'd0, 9'd0, 1'b0, 32'd320);             // release in a view does nothing
        add_row(9'd36, 9'd0, 1'b1, 32'd321);            // just right of the corner
        add_row(9'd0, 9'd18, 1'b1, 32'd322);            // just below the corner
        add_row(9'd35, 9'd17, 1'b1, 32'd323);           // back to the launcher
        add_row(9'd120, 9'd76, 1'b1, 32'd400);          // cell 4
        add_row(9'd120, 9'd76, 1'b0, 32'd410);
        add_row(9'd100, 9'd60, 1'b1, 32'd420);
        add_row(9'd100, 9'd60, 1'b0, 32'd430);          // opens the notes view
        add_row(9'd0, 9'd0, 1'b1, 32'd500);             // corner press leaves notes
        add_row(9'd511, 9'd0, 1'b1, 32'hFFFF_FFFE);     // press timer near the top
        add_row(9'd0, 9'd511, 1'b0, 32'h0000_0001);     // duration wraps through zero
        add_row(9'd79, 9'd50, 1'b1, 32'hFFFF_FFFF);
        add_row(9'd79, 9'd50, 1'b0, 32'h0000_0001);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            offer_sample(directed_rows[i].smp, directed_rows[i].typed, directed_rows[i].want);
        touch_tick = 32'h0000_0001;

        // Random phases, each under its own register setting.
        held_off = 1'b0;
        paused   = 1'b0;
        for (int phase = 0; phase < 7; phase++) begin
            wait_until_drained();
            case (phase)
                0: begin set_min = 8'd0;   set_window = 16'hFFFF; set_actions = 18'h3FFFF; end
                1: begin set_min = 8'd255; set_window = 16'd0;    set_actions = 18'h00000; end
                2: begin
                    set_min     = MIN_PRESS_RESET;
                    set_window  = WINDOW_RESET;
                    set_actions = ACTIONS_RESET;
                end
                3: begin
                    set_min     = 8'($urandom_range(0, 15));
                    set_window  = 16'($urandom_range(1, 400));
                    set_actions = 18'($urandom_range(0, 18'h3FFFF));
                end
                4: begin set_min = 8'd1;   set_window = 16'd1;    set_actions = 18'h15555; end
                5: begin
                    set_min     = 8'($urandom_range(0, 255));
                    set_window  = 16'($urandom);
                    set_actions = 18'h2AAAA;
                end
                default: begin
                    set_min     = 8'd8;
                    set_window  = 16'd200;
                    set_actions = 18'($urandom_range(0, 18'h3FFFF));
                end
            endcase
            write_register(CFG_MIN_PRESS, {10'd0, set_min});
            write_register(CFG_WINDOW, {2'd0, set_window});
            write_register(CFG_ACTIONS, set_actions);
            cfg_valid <= 1'b0;

            // One phase runs with no idling on either side.
            steady        = (phase == 3);
            counted_items = 0;
            while (counted_items < PHASE_ITEMS) begin
                // Stall the result side while samples keep coming, so the
                // block fills up and has to hold off its input.
                if (phase == 2 && !held_off && counted_items >= 20) begin
                    hold_off_req = 1'b1;
                    held_off     = 1'b1;
                end
                if (phase == 4 && !paused && counted_items >= 50) begin
                    wait_until_drained();
                    paused = 1'b1;
                end
                play_gesture();
            end
        end
        steady = 1'b0;

        wait_until_drained();
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
